/* rtl/core/bdt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bdt_pkg
// shared types, register map and byte helpers for the down-counting timer
// ----------------------------------------------------------------------------
package bdt_pkg;

    localparam int unsigned FuncWidth  = 2;
    localparam int unsigned IndexWidth = 5;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned WordWidth  = 32;

    typedef logic [ByteWidth-1:0]  t_byte;
    typedef logic [WordWidth-1:0]  t_word;
    typedef logic [IndexWidth-1:0] t_index;

    // item function codes
    typedef enum logic [FuncWidth-1:0] {
        FUNC_READ   = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_UNUSED = 2'd3
    } t_func;

    // register map, word indices
    localparam t_index RegLoad0     = 5'd0;
    localparam t_index RegLoad3     = 5'd3;
    localparam t_index RegReload0   = 5'd4;
    localparam t_index RegReload3   = 5'd7;
    localparam t_index RegEnable    = 5'd8;
    localparam t_index RegUpdate    = 5'd9;
    localparam t_index RegValue0    = 5'd10;
    localparam t_index RegValue3    = 5'd13;
    localparam t_index RegStatus    = 5'd14;
    localparam t_index RegPending   = 5'd15;
    localparam t_index RegEvEnable  = 5'd16;

    // byte lane within a word, lane 0 is the most significant byte
    function automatic t_byte get_byte(input t_word word, input logic [1:0] pos);
        t_byte b;
        case (pos)
            2'd0:    b = word[31:24];
            2'd1:    b = word[23:16];
            2'd2:    b = word[15:8];
            default: b = word[7:0];
        endcase
        return b;
    endfunction

    function automatic t_word put_byte(input t_word word, input logic [1:0] pos,
                                       input t_byte b);
        t_word w;
        w = word;
        case (pos)
            2'd0:    w[31:24] = b;
            2'd1:    w[23:16] = b;
            2'd2:    w[15:8]  = b;
            default: w[7:0]   = b;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/bus_down_timer_with_reload.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bus_down_timer_with_reload
// byte-register down-counting timer with reload and interrupt line
// ----------------------------------------------------------------------------
// Each input transfer is a register read, a register write or one timer tick,
// and each gives exactly one output transfer with the read byte and the irq
// level after that item. The register file and counter are updated at the
// edge where the input transfer is taken, and the result lands in a single
// output register: one item per cycle while the output is not stalled, with
// output valid in the cycle after the input transfer. The output register is the only thing that
// stalls the input: o_in_stall is high only while a result is held and the
// consumer stalls, and a new input is taken in the same cycle the held result
// leaves.
module bus_down_timer_with_reload import bdt_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [FuncWidth-1:0]  i_func,
    input  wire logic [IndexWidth-1:0] i_reg_index,
    input  wire logic [ByteWidth-1:0]  i_write_data,
    // output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ByteWidth-1:0]       o_read_data,
    output logic                       o_irq_line
);

    // register file and counter state
    t_word r_load, n_load;
    t_word r_reload, n_reload;
    t_byte r_enable, n_enable;
    t_word r_snapshot, n_snapshot;
    t_byte r_pending, n_pending;
    t_byte r_ev_enable, n_ev_enable;
    t_word r_count, n_count;
    logic  r_running, n_running;
    logic  r_irq, n_irq;

    // result register
    logic  r_out_valid;
    t_byte r_read_data, n_read_data;
    logic  r_irq_line;

    logic  in_xfer;
    t_func func;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign func       = t_func'(i_func);

    always_comb begin
        n_load      = r_load;
        n_reload    = r_reload;
        n_enable    = r_enable;
        n_snapshot  = r_snapshot;
        n_pending   = r_pending;
        n_ev_enable = r_ev_enable;
        n_count     = r_count;
        n_running   = r_running;
        n_irq       = r_irq;
        n_read_data = '0;

        case (func)
            FUNC_READ: begin
                case (i_reg_index) inside
                    [RegLoad0:RegLoad3]:     n_read_data = get_byte(r_load, i_reg_index[1:0]);
                    [RegReload0:RegReload3]: n_read_data = get_byte(r_reload, i_reg_index[1:0]);
                    RegEnable:               n_read_data = r_enable;
                    // value bytes start at index 10, so lane is index minus 10
                    [RegValue0:RegValue3]: begin
                        n_read_data = get_byte(r_snapshot, 2'(i_reg_index - RegValue0));
                    end
                    RegPending:              n_read_data = r_pending;
                    RegEvEnable:             n_read_data = r_ev_enable;
                    default:                 n_read_data = '0;
                endcase
            end
            FUNC_WRITE: begin
                case (i_reg_index) inside
                    [RegLoad0:RegLoad3]: begin
                        n_load = put_byte(r_load, i_reg_index[1:0], i_write_data);
                    end
                    [RegReload0:RegReload3]: begin
                        n_reload = put_byte(r_reload, i_reg_index[1:0], i_write_data);
                    end
                    RegEnable: begin
                        n_enable = i_write_data;
                        if (i_write_data == '0) begin
                            n_running = 1'b0;
                        end else if (r_enable == '0) begin
                            // rising enable loads and starts the counter
                            n_count   = r_load;
                            n_running = 1'b1;
                        end
                    end
                    RegUpdate:   n_snapshot = r_count;
                    RegPending: begin
                        if (i_write_data != '0) begin
                            n_irq = 1'b0;
                        end
                        n_pending = i_write_data;
                    end
                    RegEvEnable: n_ev_enable = i_write_data;
                    default:     ;
                endcase
            end
            FUNC_TICK: begin
                if (r_running) begin
                    if (r_count > WordWidth'(1)) begin
                        n_count = r_count - WordWidth'(1);
                    end else begin
                        // hit: count was 0 or 1
                        n_count   = '0;
                        n_running = 1'b0;
                        if (r_ev_enable != '0) begin
                            n_irq = 1'b1;
                        end
                        if (r_enable != '0) begin
                            n_count   = r_reload;
                            n_running = (r_reload != '0);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load      <= '0;
            r_reload    <= '0;
            r_enable    <= '0;
            r_snapshot  <= '0;
            r_pending   <= '0;
            r_ev_enable <= '0;
            r_count     <= '0;
            r_running   <= 1'b0;
            r_irq       <= 1'b0;
        end else if (in_xfer) begin
            r_load      <= n_load;
            r_reload    <= n_reload;
            r_enable    <= n_enable;
            r_snapshot  <= n_snapshot;
            r_pending   <= n_pending;
            r_ev_enable <= n_ev_enable;
            r_count     <= n_count;
            r_running   <= n_running;
            r_irq       <= n_irq;
        end
    end

    // output register, loaded on every input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_xfer) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_read_data <= n_read_data;
            r_irq_line  <= n_irq;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;
    assign o_irq_line  = r_irq_line;

    // a tick while stopped leaves the counter alone
    a_stopped_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_func == FUNC_TICK && !r_running) |=> $stable(r_count))
        else $error("counter moved on a tick while stopped");

    // a nonzero pending write drops the irq line in its own result
    a_pending_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_func == FUNC_WRITE && i_reg_index == RegPending
         && i_write_data != '0) |=> (o_out_valid && !o_irq_line))
        else $error("pending write did not clear irq");

    // only reads return data
    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_func != FUNC_READ) |=> (o_out_valid && o_read_data == '0))
        else $error("nonzero read data for a non-read item");

endmodule
`default_nettype wire

/* tb/bus_down_timer_with_reload_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bus_down_timer_with_reload_test
// self-checking bench for the byte-register down-counting timer
// ----------------------------------------------------------------------------
// A driver takes bus items (read, write, tick, unused code) from a queue and
// offers them on the input channel. A monitor keeps its own copy of the timer
// registers and the counter, works out the read byte and the irq level for
// every input transfer and compares each output transfer with the oldest
// expected one. A short directed run walks through the register map and a
// full load, count, hit and reload cycle. A long random run follows, made
// mostly of small counter programs and ticks so that hits keep coming. Both
// sides idle at random, the receiver once holds off for a long stretch, and
// the sender waits for an empty pipe at the start of every random phase.
// ----------------------------------------------------------------------------
module bus_down_timer_with_reload_test;
    import bdt_pkg::*;

    localparam int unsigned MaxGap      = 19;
    localparam int unsigned LongHold    = 300;
    localparam int unsigned PhaseCount  = 6;
    localparam int unsigned PhaseItems  = 225;
    localparam int unsigned TailCycles  = 10;

    // one bus item as the driver offers it
    typedef struct {
        t_func       func;
        t_index      idx;
        t_byte       wd;
        int unsigned gap;    // idle cycles before it is offered
        bit          drain;  // offer only once every reply has come back
    } t_bus_item;

    // what one output transfer carries
    typedef struct packed {
        t_byte read_data;
        logic  irq_line;
    } t_timer_reply;

    // dut ports
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic [FuncWidth-1:0]  i_func       = FUNC_READ;
    logic [IndexWidth-1:0] i_reg_index  = '0;
    logic [ByteWidth-1:0]  i_write_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic [ByteWidth-1:0]  o_read_data;
    logic                  o_irq_line;

    t_bus_item    pending_items[$];
    t_timer_reply expected_replies[$];

    // handshake flags, set at the rising edge and used by the drivers at the falling one
    bit          in_fire   = 1'b0;
    bit          out_fire  = 1'b0;
    bit          tx_idle   = 1'b0;
    bit          rx_idle   = 1'b1;
    bit          hold_req  = 1'b0;
    int unsigned gap_cnt   = 0;
    int unsigned stall_cnt = 0;
    int unsigned hold_cnt  = 0;
    int unsigned err_cnt   = 0;

    // timer model, reset values
    t_word m_load     = '0;
    t_word m_reload   = '0;
    t_byte m_enable   = '0;
    t_word m_snapshot = '0;
    t_byte m_pending  = '0;
    t_byte m_ev_en    = '0;
    t_word m_count    = '0;
    logic  m_running  = 1'b0;
    logic  m_irq      = 1'b0;

    bus_down_timer_with_reload dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_reg_index  (i_reg_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_data  (o_read_data),
        .o_irq_line   (o_irq_line)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // timer model
    // ------------------------------------------------------------------------

    // lane 0 is the most significant byte
    function automatic t_byte byte_at(input t_word w, input logic [1:0] lane);
        return t_byte'(w >> (ByteWidth * (3 - int'(lane))));
    endfunction

    function automatic t_word with_byte(input t_word w, input logic [1:0] lane,
                                        input t_byte b);
        int unsigned sh;
        sh = ByteWidth * (3 - int'(lane));
        return (w & ~(t_word'({ByteWidth{1'b1}}) << sh)) | (t_word'(b) << sh);
    endfunction

    // apply one item to the model and return the reply it causes
    task automatic advance_timer(input t_func func, input t_index idx, input t_byte wd,
                                 output t_timer_reply reply);
        t_byte rd;
        rd = '0;
        case (func)
            FUNC_READ: begin
                // unknown indices fall through and read as zero
                if (idx <= RegLoad3) begin
                    rd = byte_at(m_load, 2'(idx - RegLoad0));
                end else if (idx <= RegReload3) begin
                    rd = byte_at(m_reload, 2'(idx - RegReload0));
                end else if (idx == RegEnable) begin
                    rd = m_enable;
                end else if (idx >= RegValue0 && idx <= RegValue3) begin
                    rd = byte_at(m_snapshot, 2'(idx - RegValue0));
                end else if (idx == RegPending) begin
                    rd = m_pending;
                end else if (idx == RegEvEnable) begin
                    rd = m_ev_en;
                end
            end
            FUNC_WRITE: begin
                // value, status and unknown indices are dropped
                if (idx <= RegLoad3) begin
                    m_load = with_byte(m_load, 2'(idx - RegLoad0), wd);
                end else if (idx <= RegReload3) begin
                    m_reload = with_byte(m_reload, 2'(idx - RegReload0), wd);
                end else if (idx == RegEnable) begin
                    // only a zero to nonzero change loads and starts
                    if (wd == '0) begin
                        m_running = 1'b0;
                    end else if (m_enable == '0) begin
                        m_count   = m_load;
                        m_running = 1'b1;
                    end
                    m_enable = wd;
                end else if (idx == RegUpdate) begin
                    m_snapshot = m_count;
                end else if (idx == RegPending) begin
                    if (wd != '0) m_irq = 1'b0;
                    m_pending = wd;
                end else if (idx == RegEvEnable) begin
                    m_ev_en = wd;
                end
            end
            FUNC_TICK: begin
                if (m_running) begin
                    if (m_count > 1) begin
                        m_count = m_count - 1;
                    end else begin
                        // hit: a count of zero or one before the tick
                        m_count   = '0;
                        m_running = 1'b0;
                        if (m_ev_en != '0) m_irq = 1'b1;
                        if (m_enable != '0) begin
                            m_count   = m_reload;
                            m_running = (m_reload != '0);
                        end
                    end
                end
            end
            default: ;
        endcase
        reply.read_data = rd;
        reply.irq_line  = m_irq;
    endtask

    // ------------------------------------------------------------------------
    // monitor: both channels at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_timer_reply want;
        t_timer_reply next_reply;
        in_fire  = 1'b0;
        out_fire = 1'b0;
        if (i_rst_n) begin
            // output transfer against the oldest expected reply
            if (o_out_valid && !i_out_stall) begin
                out_fire = 1'b1;
                if (expected_replies.size() == 0) begin
                    err_cnt++;
                    $display("%0t: reply with none expected, actual read_data %02h irq %0b",
                             $time, o_read_data, o_irq_line);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_read_data !== want.read_data) begin
                        err_cnt++;
                        $display("%0t: read_data mismatch, expected %02h actual %02h",
                                 $time, want.read_data, o_read_data);
                    end
                    if (o_irq_line !== want.irq_line) begin
                        err_cnt++;
                        $display("%0t: irq_line mismatch, expected %0b actual %0b",
                                 $time, want.irq_line, o_irq_line);
                    end
                end
            end
            // input transfer runs through the model
            if (i_in_valid && !o_in_stall) begin
                in_fire = 1'b1;
                advance_timer(t_func'(i_func), i_reg_index, i_write_data, next_reply);
                expected_replies.push_back(next_reply);
            end
        end
    end

    // ------------------------------------------------------------------------
    // input driver: falling edge, one item from the queue per transfer
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_in
        t_bus_item next_item;
        logic      next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || in_fire) begin
            // the channel is free: count the gap, then offer the next item
            next_valid = 1'b0;
            if (pending_items.size() != 0) begin
                if (pending_items[0].drain && expected_replies.size() != 0) begin
                    // sender pause until the pipe is empty
                end else if (gap_cnt < pending_items[0].gap) begin
                    gap_cnt++;
                end else begin
                    next_item    = pending_items.pop_front();
                    gap_cnt      = 0;
                    next_valid   = 1'b1;
                    i_func       <= next_item.func;
                    i_reg_index  <= next_item.idx;
                    i_write_data <= next_item.wd;
                end
            end
        end
        // a stalled item stays as it is
        i_in_valid <= next_valid;
    end

    // ------------------------------------------------------------------------
    // output receiver: falling edge, random stall per transfer plus one long hold
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : drive_out
        if (hold_req) begin
            hold_cnt = LongHold;
            hold_req = 1'b0;
        end
        if (out_fire) begin
            // now and then switch between idling and full rate
            if ($urandom_range(0, 63) == 0) rx_idle = !rx_idle;
            stall_cnt = rx_idle ? $urandom_range(0, MaxGap) : 0;
        end
        if (hold_cnt != 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (stall_cnt != 0) begin
            stall_cnt--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    task automatic queue_item(input t_func func, input t_index idx, input t_byte wd,
                              input bit drain = 1'b0);
        t_bus_item it;
        it.func  = func;
        it.idx   = idx;
        it.wd    = wd;
        it.gap   = tx_idle ? $urandom_range(0, MaxGap) : 0;
        it.drain = drain;
        pending_items.push_back(it);
    endtask

    // mostly small counter programs and ticks, some noise on top
    task automatic queue_random(input bit drain);
        int unsigned pick;
        t_index      idx;
        t_byte       wd;
        t_func       func;
        pick = $urandom_range(0, 99);
        func = FUNC_WRITE;
        idx  = t_index'($urandom_range(0, 31));
        wd   = t_byte'($urandom_range(0, 255));
        if (pick < 45) begin
            func = FUNC_TICK;
        end else if (pick < 60) begin
            func = FUNC_READ;
            if ($urandom_range(0, 7) != 0) idx = t_index'($urandom_range(0, RegEvEnable));
        end else if (pick < 70) begin
            // load or reload lane, low lane small so that hits come often
            idx = t_index'($urandom_range(RegLoad0, RegReload3));
            if (idx == RegLoad3 || idx == RegReload3) begin
                wd = t_byte'($urandom_range(0, 12));
            end else if ($urandom_range(0, 15) != 0) begin
                wd = '0;
            end
        end else if (pick < 78) begin
            idx = RegEnable;
            if ($urandom_range(0, 2) == 0) wd = '0;
        end else if (pick < 82) begin
            idx = RegUpdate;
        end else if (pick < 86) begin
            idx = RegPending;
            if ($urandom_range(0, 3) == 0) wd = '0;
        end else if (pick < 90) begin
            idx = RegEvEnable;
            if ($urandom_range(0, 3) == 0) wd = '0;
        end else if (pick >= 95) begin
            func = FUNC_UNUSED;
        end
        queue_item(func, idx, wd, drain);
    endtask

    initial begin : stimulus
        int unsigned total;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: register map, one full count to a hit and reload
        queue_item(FUNC_WRITE, RegEvEnable, 8'hff);
        queue_item(FUNC_WRITE, RegLoad0, 8'hff);
        queue_item(FUNC_READ, RegLoad0, 8'h00);
        for (int k = 0; k < 4; k++) begin
            queue_item(FUNC_WRITE, RegLoad0 + t_index'(k), (k == 3) ? 8'd3 : 8'd0);
        end
        for (int k = 0; k < 4; k++) begin
            queue_item(FUNC_WRITE, RegReload0 + t_index'(k), (k == 3) ? 8'd2 : 8'd0);
        end
        queue_item(FUNC_WRITE, RegEnable, 8'h01);
        // already enabled, no restart
        queue_item(FUNC_WRITE, RegEnable, 8'h80);
        queue_item(FUNC_TICK, RegLoad0, 8'h00);
        queue_item(FUNC_TICK, RegLoad0, 8'h00);
        // hit: irq rises and the counter reloads
        queue_item(FUNC_TICK, RegLoad0, 8'h00);
        queue_item(FUNC_WRITE, RegUpdate, 8'h00);
        queue_item(FUNC_READ, RegValue3, 8'h00);
        queue_item(FUNC_WRITE, RegPending, 8'hff);
        queue_item(FUNC_READ, RegPending, 8'h00);
        // read-only and unknown writes are dropped, unknown reads give zero
        queue_item(FUNC_WRITE, RegStatus, 8'haa);
        queue_item(FUNC_WRITE, t_index'(31), 8'h55);
        queue_item(FUNC_READ, t_index'(31), 8'h00);
        queue_item(FUNC_UNUSED, RegEnable, 8'h00);
        // stop, then a tick while stopped
        queue_item(FUNC_WRITE, RegEnable, 8'h00);
        queue_item(FUNC_TICK, RegLoad0, 8'h00);
        queue_item(FUNC_READ, RegEnable, 8'h00);

        // random phases, each opening with an empty pipe
        for (int ph = 0; ph < PhaseCount; ph++) begin
            tx_idle = (ph % 3 != 0);
            for (int n = 0; n < PhaseItems; n++) queue_random(n == 0);
        end
        total = pending_items.size();

        // long receiver hold in the middle of a full-rate phase
        while (pending_items.size() > total - 120) @(posedge i_clk);
        hold_req = 1'b1;

        while (pending_items.size() != 0 || i_in_valid) @(posedge i_clk);
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (err_cnt == 0 && expected_replies.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin : watchdog
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
